### rtl/c_minus_tokenizer_core_macros.svh
// ----------------------------------------------------------------------------
// c_minus_tokenizer_core_macros.svh
// Assertion shorthands for the tokenizer checker. All of them sample on the
// rising edge of i_clk and are switched off while reset is held.
// ----------------------------------------------------------------------------
`ifndef C_MINUS_TOKENIZER_CORE_MACROS_SVH
`define C_MINUS_TOKENIZER_CORE_MACROS_SVH

// Condition must hold at every sampled edge
`define CTOK_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define CTOK_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/ctok_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctok_pkg
// Shared types and constants of the C-minus tokenizer: token kinds, byte
// classes, lexer stages, keyword spellings and queue entry layouts.
// ----------------------------------------------------------------------------
package ctok_pkg;

    // Fixed widths of the result fields
    localparam int KIND_W = 5;
    localparam int LINE_W = 16;
    localparam int OFS_W  = 20;
    localparam int LEN_W  = 16;

    // Default sizes of the adjustable storage
    localparam int KEYWORD_CHARS_DEF = 6;
    localparam int OFFSET_BITS_DEF   = 20;
    localparam int LINE_BITS_DEF     = 16;

    // Entries in each of the two queues
    localparam int QUEUE_DEPTH = 2;

    // Token length saturates here
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    typedef logic [KIND_W-1:0] t_kind;

    // Token kinds
    localparam t_kind K_END    = 5'd0;
    localparam t_kind K_ID     = 5'd1;
    localparam t_kind K_NUM    = 5'd2;
    localparam t_kind K_VOID   = 5'd3;
    localparam t_kind K_INT    = 5'd4;
    localparam t_kind K_IF     = 5'd5;
    localparam t_kind K_ELSE   = 5'd6;
    localparam t_kind K_WHILE  = 5'd7;
    localparam t_kind K_RETURN = 5'd8;
    localparam t_kind K_PLUS   = 5'd9;
    localparam t_kind K_MINUS  = 5'd10;
    localparam t_kind K_MUL    = 5'd11;
    localparam t_kind K_DIV    = 5'd12;
    localparam t_kind K_LT     = 5'd13;
    localparam t_kind K_LE     = 5'd14;
    localparam t_kind K_GT     = 5'd15;
    localparam t_kind K_GE     = 5'd16;
    localparam t_kind K_ASSIGN = 5'd17;
    localparam t_kind K_EQ     = 5'd18;
    localparam t_kind K_NE     = 5'd19;
    localparam t_kind K_SEMI   = 5'd20;
    localparam t_kind K_COMMA  = 5'd21;
    localparam t_kind K_LPAREN = 5'd22;
    localparam t_kind K_RPAREN = 5'd23;
    localparam t_kind K_LBRACK = 5'd24;
    localparam t_kind K_RBRACK = 5'd25;
    localparam t_kind K_LBRACE = 5'd26;
    localparam t_kind K_RBRACE = 5'd27;
    localparam t_kind K_ERROR  = 5'd28;

    // Keyword spellings, first character in the top byte
    localparam logic [31:0] KW_VOID   = "void";
    localparam logic [23:0] KW_INT    = "int";
    localparam logic [15:0] KW_IF     = "if";
    localparam logic [31:0] KW_ELSE   = "else";
    localparam logic [39:0] KW_WHILE  = "while";
    localparam logic [47:0] KW_RETURN = "return";

    // Character values with a role of their own
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_NUL     = 8'h00;

    // Byte classes as seen by the lexer
    typedef enum logic [3:0] {
        CC_ALPHA,
        CC_DIGIT,
        CC_SPACE,
        CC_NEWLINE,
        CC_ZERO,
        CC_SINGLE,
        CC_SLASH,
        CC_STAR,
        CC_LESS,
        CC_GREATER,
        CC_EQUAL,
        CC_BANG,
        CC_INVALID
    } t_char_cls;

    // Lexer stages
    typedef enum logic [3:0] {
        ST_START,
        ST_ID,
        ST_NUM,
        ST_DIV,
        ST_COMMENT,
        ST_COMMENT_STAR,
        ST_LESS,
        ST_GREATER,
        ST_ASSIGN,
        ST_NOT
    } t_lex_stage;

    // One classified source byte
    typedef struct packed {
        logic [7:0] ch;
        t_char_cls  cls;
        t_kind      single_kind;
    } t_byte_info;

    // One finished token
    typedef struct packed {
        t_kind             kind;
        logic [LINE_W-1:0] line;
        logic [OFS_W-1:0]  start;
        logic [LEN_W-1:0]  len;
        logic              last;
    } t_token;

endpackage

### rtl/c_minus_tokenizer_core.sv
`timescale 1ns / 1ps
// An accepted byte is registered in the byte queue; the lexer writes its token into the
// result queue, which drives the result ports. Throughput: one byte per cycle while the
// result queue has room, set by the lexer step in the back end. A byte that closes a token
// and is itself a one-character token, end or error is held and looked at again; each look
// writes one token to the result queue. Reset: synchronous, active low; both queues empty,
// lexer at start stage, line one, offsets zero. No clearing pass; the block is ready in the cycle after reset.
// ----------------------------------------------------------------------------
// c_minus_tokenizer_core
// C-minus tokenizer: byte classifier and queue in front, lexer state machine
// behind it, token queue at the output.
// ----------------------------------------------------------------------------
module c_minus_tokenizer_core #(
    parameter int KEYWORD_CHARS = ctok_pkg::KEYWORD_CHARS_DEF,
    parameter int OFFSET_BITS   = ctok_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS     = ctok_pkg::LINE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [7:0]                  i_source_byte,
    output logic                        empty,
    input  logic                        pop,
    output logic [ctok_pkg::KIND_W-1:0] o_token_kind,
    output logic [ctok_pkg::LINE_W-1:0] o_line_number,
    output logic [ctok_pkg::OFS_W-1:0]  o_start_offset,
    output logic [ctok_pkg::LEN_W-1:0]  o_token_length,
    output logic                        o_run_last
);

    import ctok_pkg::*;

    localparam int TOK_W = $bits(t_token);

    logic             w_head_valid;
    t_byte_info       w_head;
    logic             w_head_pop;
    logic             w_tok_full;
    logic             w_tok_push;
    t_token           w_tok;
    logic [TOK_W-1:0] w_out_bits;
    t_token           w_out;

    // Classify and queue incoming bytes
    ctok_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_source_byte (i_source_byte),
        .o_head_valid  (w_head_valid),
        .o_head        (w_head),
        .i_head_pop    (w_head_pop)
    );

    // Run the lexer
    ctok_lexer #(
        .KEYWORD_CHARS (KEYWORD_CHARS),
        .OFFSET_BITS   (OFFSET_BITS),
        .LINE_BITS     (LINE_BITS)
    ) u_lexer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_head_pop   (w_head_pop),
        .i_tok_full   (w_tok_full),
        .o_tok_push   (w_tok_push),
        .o_tok        (w_tok)
    );

    // Hold finished tokens until the consumer takes them
    ctok_fifo #(
        .DATA_W (TOK_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_tok_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_tok_push),
        .i_wdata (w_tok),
        .o_full  (w_tok_full),
        .i_rd    (pop),
        .o_rdata (w_out_bits),
        .o_empty (empty)
    );

    assign w_out          = t_token'(w_out_bits);
    assign o_token_kind   = w_out.kind;
    assign o_line_number  = w_out.line;
    assign o_start_offset = w_out.start;
    assign o_token_length = w_out.len;
    assign o_run_last     = w_out.last;

endmodule

### rtl/ctok_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctok_fifo
// Small first-in first-out queue with registered storage; used on both the
// byte side and the token side of the tokenizer.
// ----------------------------------------------------------------------------
module ctok_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic              o_full,
    input  logic              i_rd,
    output logic [DATA_W-1:0] o_rdata,
    output logic              o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wptr, n_wptr;
    logic [PTR_W-1:0]  r_rptr, n_rptr;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              w_wr;
    logic              w_rd;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rptr];

    assign w_wr = i_wr && !o_full;
    assign w_rd = i_rd && !o_empty;

    // Advance pointers and occupancy
    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (w_wr) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_rd) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // Store the incoming entry
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

### rtl/ctok_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctok_front
// Front end: classifies each accepted source byte and queues it, together
// with its class, for the lexer.
// ----------------------------------------------------------------------------
module ctok_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic [7:0]            i_source_byte,
    output logic                  o_head_valid,
    output ctok_pkg::t_byte_info  o_head,
    input  logic                  i_head_pop
);

    import ctok_pkg::*;

    localparam int INFO_W = $bits(t_byte_info);

    t_byte_info        w_info;
    logic [INFO_W-1:0] w_head_bits;
    logic              w_empty;

    // Classify the incoming byte
    always_comb begin
        w_info.ch          = i_source_byte;
        w_info.cls         = CC_INVALID;
        w_info.single_kind = K_ERROR;
        if ((i_source_byte >= "a" && i_source_byte <= "z") ||
            (i_source_byte >= "A" && i_source_byte <= "Z")) begin
            w_info.cls = CC_ALPHA;
        end else if (i_source_byte >= "0" && i_source_byte <= "9") begin
            w_info.cls = CC_DIGIT;
        end else if (i_source_byte == CH_NEWLINE) begin
            w_info.cls = CC_NEWLINE;
        end else if (i_source_byte == " " ||
                     (i_source_byte >= 8'h09 && i_source_byte <= 8'h0D)) begin
            w_info.cls = CC_SPACE;
        end else begin
            case (i_source_byte)
                CH_NUL: w_info.cls = CC_ZERO;
                "/":    w_info.cls = CC_SLASH;
                "*":    w_info.cls = CC_STAR;
                "<":    w_info.cls = CC_LESS;
                ">":    w_info.cls = CC_GREATER;
                "=":    w_info.cls = CC_EQUAL;
                "!":    w_info.cls = CC_BANG;
                "+": begin
                    w_info.cls         = CC_SINGLE;
                    w_info.single_kind = K_PLUS;
                end
                "-": begin
                    w_info.cls         = CC_SINGLE;
                    w_info.single_kind = K_MINUS;
                end
                ";": begin
                    w_info.cls         = CC_SINGLE;
                    w_info.single_kind = K_SEMI;
                end
                ",": begin
                    w_info.cls         = CC_SINGLE;
                    w_info.single_kind = K_COMMA;
                end
                "(": begin
                    w_info.cls         = CC_SINGLE;
                    w_info.single_kind = K_LPAREN;
                end
                ")": begin
                    w_info.cls         = CC_SINGLE;
                    w_info.single_kind = K_RPAREN;
                end
                "[": begin
                    w_info.cls         = CC_SINGLE;
                    w_info.single_kind = K_LBRACK;
                end
                "]": begin
                    w_info.cls         = CC_SINGLE;
                    w_info.single_kind = K_RBRACK;
                end
                "{": begin
                    w_info.cls         = CC_SINGLE;
                    w_info.single_kind = K_LBRACE;
                end
                "}": begin
                    w_info.cls         = CC_SINGLE;
                    w_info.single_kind = K_RBRACE;
                end
                default: w_info.cls = CC_INVALID;
            endcase
        end
    end

    // Hold classified bytes until the lexer takes them
    ctok_fifo #(
        .DATA_W (INFO_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_byte_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_push),
        .i_wdata (w_info),
        .o_full  (o_full),
        .i_rd    (i_head_pop),
        .o_rdata (w_head_bits),
        .o_empty (w_empty)
    );

    assign o_head_valid = !w_empty;
    assign o_head       = t_byte_info'(w_head_bits);

endmodule

### rtl/ctok_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctok_lexer
// Back end: the lexer state machine. Takes one classified byte per cycle
// while the result queue has room, keeps line, position and token
// bookkeeping, and writes finished tokens to the result queue. A byte that
// ends a token and starts an emitting one is held and looked at again.
// ----------------------------------------------------------------------------
module ctok_lexer #(
    parameter int KEYWORD_CHARS = ctok_pkg::KEYWORD_CHARS_DEF,
    parameter int OFFSET_BITS   = ctok_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS     = ctok_pkg::LINE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_head_valid,
    input  ctok_pkg::t_byte_info i_head,
    output logic                 o_head_pop,
    input  logic                 i_tok_full,
    output logic                 o_tok_push,
    output ctok_pkg::t_token     o_tok
);

    import ctok_pkg::*;

    localparam int KW_IDX_W = $clog2(KEYWORD_CHARS);

    // State
    t_lex_stage             r_stage, n_stage;
    logic                   r_halted, n_halted;
    logic [LINE_BITS-1:0]   r_line, n_line;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [OFFSET_BITS-1:0] r_tok_start, n_tok_start;
    logic [LEN_W-1:0]       r_count, n_count;
    logic [7:0]             r_kw_buf [KEYWORD_CHARS];

    // Keyword buffer write
    logic                   w_buf_we;
    logic [KW_IDX_W-1:0]    w_buf_idx;

    // Start-stage decode of the head byte
    logic                   w_st_emits;
    t_kind                  w_st_kind;
    logic [LEN_W-1:0]       w_st_len;
    logic                   w_st_halt;
    t_lex_stage             w_st_stage;
    logic                   w_st_begin;

    // Per-cycle control
    logic                   w_active;
    logic                   w_consume;
    logic                   w_do_start;
    logic                   w_add;
    logic                   w_line_inc;
    t_kind                  w_id_kind;
    t_kind                  w_kind;
    logic [OFFSET_BITS-1:0] w_start;
    logic [LEN_W-1:0]       w_len;
    logic                   w_last;

    // Classify the identifier held in the keyword buffer
    always_comb begin
        w_id_kind = K_ID;
        if (r_count == LEN_W'(4) &&
            {r_kw_buf[0], r_kw_buf[1], r_kw_buf[2], r_kw_buf[3]} == KW_VOID) begin
            w_id_kind = K_VOID;
        end else if (r_count == LEN_W'(3) &&
                     {r_kw_buf[0], r_kw_buf[1], r_kw_buf[2]} == KW_INT) begin
            w_id_kind = K_INT;
        end else if (r_count == LEN_W'(2) &&
                     {r_kw_buf[0], r_kw_buf[1]} == KW_IF) begin
            w_id_kind = K_IF;
        end else if (r_count == LEN_W'(4) &&
                     {r_kw_buf[0], r_kw_buf[1], r_kw_buf[2], r_kw_buf[3]} == KW_ELSE) begin
            w_id_kind = K_ELSE;
        end else if (r_count == LEN_W'(5) &&
                     {r_kw_buf[0], r_kw_buf[1], r_kw_buf[2], r_kw_buf[3],
                      r_kw_buf[4]} == KW_WHILE) begin
            w_id_kind = K_WHILE;
        end else if (r_count == LEN_W'(6) &&
                     {r_kw_buf[0], r_kw_buf[1], r_kw_buf[2], r_kw_buf[3],
                      r_kw_buf[4], r_kw_buf[5]} == KW_RETURN) begin
            w_id_kind = K_RETURN;
        end
    end

    // Decode what the start stage would do with the head byte
    always_comb begin
        w_st_emits = 1'b0;
        w_st_kind  = K_ERROR;
        w_st_len   = '0;
        w_st_halt  = 1'b0;
        w_st_stage = ST_START;
        w_st_begin = 1'b0;
        case (i_head.cls)
            CC_ALPHA: begin
                w_st_stage = ST_ID;
                w_st_begin = 1'b1;
            end
            CC_DIGIT: begin
                w_st_stage = ST_NUM;
                w_st_begin = 1'b1;
            end
            CC_SLASH:   w_st_stage = ST_DIV;
            CC_LESS: begin
                w_st_stage = ST_LESS;
                w_st_begin = 1'b1;
            end
            CC_GREATER: begin
                w_st_stage = ST_GREATER;
                w_st_begin = 1'b1;
            end
            CC_EQUAL: begin
                w_st_stage = ST_ASSIGN;
                w_st_begin = 1'b1;
            end
            CC_BANG: begin
                w_st_stage = ST_NOT;
                w_st_begin = 1'b1;
            end
            CC_SINGLE: begin
                w_st_emits = 1'b1;
                w_st_kind  = i_head.single_kind;
                w_st_len   = LEN_W'(1);
            end
            CC_STAR: begin
                w_st_emits = 1'b1;
                w_st_kind  = K_MUL;
                w_st_len   = LEN_W'(1);
            end
            CC_ZERO: begin
                w_st_emits = 1'b1;
                w_st_kind  = K_END;
                w_st_halt  = 1'b1;
            end
            CC_SPACE, CC_NEWLINE: w_st_stage = ST_START;
            default: begin
                w_st_emits = 1'b1;
                w_st_kind  = K_ERROR;
                w_st_halt  = 1'b1;
            end
        endcase
    end

    // Next state and token output
    always_comb begin
        n_stage     = r_stage;
        n_halted    = r_halted;
        n_line      = r_line;
        n_pos       = r_pos;
        n_tok_start = r_tok_start;
        n_count     = r_count;
        w_buf_we    = 1'b0;
        w_buf_idx   = '0;
        w_active    = i_head_valid && !r_halted && !i_tok_full;
        w_consume   = 1'b1;
        w_do_start  = 1'b0;
        w_add       = 1'b0;
        w_line_inc  = 1'b0;
        o_tok_push  = 1'b0;
        w_kind      = K_END;
        w_start     = r_pos;
        w_len       = '0;
        w_last      = 1'b1;

        if (w_active) begin
            case (r_stage)
                ST_ID: begin
                    if (i_head.cls == CC_ALPHA) begin
                        w_add = 1'b1;
                    end else begin
                        o_tok_push = 1'b1;
                        w_kind     = w_id_kind;
                        w_start    = r_tok_start;
                        w_len      = r_count;
                        w_consume  = 1'b0;
                    end
                end
                ST_NUM: begin
                    if (i_head.cls == CC_DIGIT) begin
                        w_add = 1'b1;
                    end else begin
                        o_tok_push = 1'b1;
                        w_kind     = K_NUM;
                        w_start    = r_tok_start;
                        w_len      = r_count;
                        w_consume  = 1'b0;
                    end
                end
                ST_DIV: begin
                    if (i_head.cls == CC_STAR) begin
                        n_stage = ST_COMMENT;
                    end else begin
                        o_tok_push = 1'b1;
                        w_kind     = K_DIV;
                        w_start    = r_tok_start;
                        w_len      = LEN_W'(1);
                        w_consume  = 1'b0;
                    end
                end
                ST_COMMENT, ST_COMMENT_STAR: begin
                    // End of text closes the stream even inside a comment
                    if (i_head.cls == CC_ZERO) begin
                        o_tok_push = 1'b1;
                        w_kind     = K_END;
                        n_halted   = 1'b1;
                    end else if (r_stage == ST_COMMENT_STAR && i_head.cls == CC_SLASH) begin
                        n_stage = ST_START;
                    end else if (i_head.cls == CC_STAR) begin
                        n_stage = ST_COMMENT_STAR;
                    end else begin
                        n_stage    = ST_COMMENT;
                        w_line_inc = (i_head.cls == CC_NEWLINE);
                    end
                end
                ST_LESS, ST_GREATER, ST_ASSIGN: begin
                    n_stage    = ST_START;
                    o_tok_push = 1'b1;
                    w_start    = r_tok_start;
                    if (i_head.cls == CC_EQUAL) begin
                        w_len  = LEN_W'(2);
                        w_kind = (r_stage == ST_LESS)    ? K_LE :
                                 (r_stage == ST_GREATER) ? K_GE : K_EQ;
                    end else begin
                        w_len     = LEN_W'(1);
                        w_kind    = (r_stage == ST_LESS)    ? K_LT :
                                    (r_stage == ST_GREATER) ? K_GT : K_ASSIGN;
                        w_consume = 1'b0;
                    end
                end
                ST_NOT: begin
                    n_stage    = ST_START;
                    o_tok_push = 1'b1;
                    if (i_head.cls == CC_EQUAL) begin
                        w_kind  = K_NE;
                        w_start = r_tok_start;
                        w_len   = LEN_W'(2);
                    end else begin
                        // Lone bang: error at the following byte
                        w_kind   = K_ERROR;
                        n_halted = 1'b1;
                    end
                end
                default: w_do_start = 1'b1;
            endcase

            // Re-examine a byte that closed the pending token
            if (!w_consume) begin
                if (w_st_emits) begin
                    w_last  = 1'b0;
                    n_stage = ST_START;
                end else begin
                    w_do_start = 1'b1;
                    w_consume  = 1'b1;
                end
            end

            // Apply the start stage
            if (w_do_start) begin
                n_stage = w_st_stage;
                if (w_st_emits) begin
                    o_tok_push = 1'b1;
                    w_kind     = w_st_kind;
                    w_start    = r_pos;
                    w_len      = w_st_len;
                    n_halted   = w_st_halt;
                end
                if (w_st_begin || i_head.cls == CC_SLASH) begin
                    n_tok_start = r_pos;
                end
                if (w_st_begin) begin
                    n_count  = LEN_W'(1);
                    w_buf_we = 1'b1;
                end
                w_line_inc = (i_head.cls == CC_NEWLINE);
            end

            // Extend the current identifier or number
            if (w_add) begin
                if (r_count < LEN_W'(KEYWORD_CHARS)) begin
                    w_buf_we  = 1'b1;
                    w_buf_idx = r_count[KW_IDX_W-1:0];
                end
                if (r_count != LEN_MAX) begin
                    n_count = r_count + 1'b1;
                end
            end

            // Count lines, saturating
            if (w_line_inc && r_line != '1) begin
                n_line = r_line + 1'b1;
            end

            if (w_consume) begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    // Drop bytes after a halt; otherwise pop each consumed byte
    assign o_head_pop = i_head_valid && (r_halted || (w_active && w_consume));

    assign o_tok.kind  = w_kind;
    assign o_tok.line  = LINE_W'(r_line);
    assign o_tok.start = OFS_W'(w_start);
    assign o_tok.len   = w_len;
    assign o_tok.last  = w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage     <= ST_START;
            r_halted    <= 1'b0;
            r_line      <= LINE_BITS'(1);
            r_pos       <= '0;
            r_tok_start <= '0;
            r_count     <= '0;
        end else begin
            r_stage     <= n_stage;
            r_halted    <= n_halted;
            r_line      <= n_line;
            r_pos       <= n_pos;
            r_tok_start <= n_tok_start;
            r_count     <= n_count;
        end
    end

    // Keep the first characters of the current token
    always_ff @(posedge i_clk) begin
        if (w_buf_we) begin
            r_kw_buf[w_buf_idx] <= i_head.ch;
        end
    end

endmodule

### rtl/ctok_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctok_checker
// Port-level checks of the tokenizer: result queue state after reset and
// consistency of the token fields shown to the consumer.
// ----------------------------------------------------------------------------
`include "c_minus_tokenizer_core_macros.svh"

module ctok_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        push,
    input logic                        full,
    input logic [7:0]                  i_source_byte,
    input logic                        empty,
    input logic                        pop,
    input logic [ctok_pkg::KIND_W-1:0] o_token_kind,
    input logic [ctok_pkg::LINE_W-1:0] o_line_number,
    input logic [ctok_pkg::OFS_W-1:0]  o_start_offset,
    input logic [ctok_pkg::LEN_W-1:0]  o_token_length,
    input logic                        o_run_last
);

    import ctok_pkg::*;

    // Reset leaves no token waiting
    `CTOK_ASSERT_IMPLIES(a_empty_after_reset, $past(!i_rst_n), empty, "token shown after reset")

    // Only defined kinds reach the consumer
    `CTOK_ASSERT_IMPLIES(a_kind_range, !empty, o_token_kind <= K_ERROR, "undefined token kind")

    // End and error tokens carry no text
    `CTOK_ASSERT_IMPLIES(a_marker_len, !empty && (o_token_kind == K_END || o_token_kind == K_ERROR), o_token_length == '0, "end or error token with text")

    // Operators and brackets are one or two characters long
    `CTOK_ASSERT_IMPLIES(a_op_len, !empty && o_token_kind >= K_PLUS && o_token_kind <= K_RBRACE, o_token_length == 16'd1 || o_token_length == 16'd2, "operator length out of range")

endmodule

bind c_minus_tokenizer_core ctok_checker u_ctok_checker (.*);

### test/c_minus_tokenizer_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_minus_tokenizer_core_checker
// Watches the byte and token queues of the tokenizer. Every accepted source
// byte is run through a lexer of its own, which produces the tokens that
// byte should cause. Each popped token is compared against the oldest one
// still waiting.
// ----------------------------------------------------------------------------
module c_minus_tokenizer_core_checker
    import ctok_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_full,
    input  logic [7:0]        i_source_byte,
    input  logic              i_empty,
    input  logic              i_pop,
    input  logic [KIND_W-1:0] i_token_kind,
    input  logic [LINE_W-1:0] i_line_number,
    input  logic [OFS_W-1:0]  i_start_offset,
    input  logic [LEN_W-1:0]  i_token_length,
    input  logic              i_run_last,
    output int                o_mismatch_count,
    output int                o_tokens_pending
);

    localparam int REPORT_LIMIT = 10;

    // Lexer state of the predictor
    t_lex_stage        lex_stage = ST_START;
    logic [LINE_W-1:0] line_cnt  = 16'd1;
    logic [OFS_W-1:0]  byte_pos  = '0;
    logic [OFS_W-1:0]  tok_start = '0;
    logic [LEN_W-1:0]  char_cnt  = '0;
    logic [7:0]        kw_buf [KEYWORD_CHARS_DEF];
    bit                halted    = 1'b0;

    t_token expected_tokens [$];
    t_token byte_tokens [$];
    int     mismatch_count = 0;

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // Count a line, holding at the top value
    function automatic void bump_line();
        if (line_cnt != '1) begin
            line_cnt = line_cnt + 1'b1;
        end
    endfunction

    // Keep the first characters for the keyword match; saturate the length
    function automatic void add_char(logic [7:0] c);
        if (char_cnt < KEYWORD_CHARS_DEF) begin
            kw_buf[char_cnt] = c;
        end
        if (char_cnt != LEN_MAX) begin
            char_cnt = char_cnt + 1'b1;
        end
    endfunction

    function automatic void open_token(t_lex_stage stage, logic [7:0] c);
        lex_stage = stage;
        tok_start = byte_pos;
        char_cnt  = '0;
        add_char(c);
    endfunction

    function automatic void emit(t_kind kind, logic [OFS_W-1:0] start, logic [LEN_W-1:0] len);
        t_token tok;
        tok.kind  = kind;
        tok.line  = line_cnt;
        tok.start = start;
        tok.len   = len;
        tok.last  = 1'b0;
        byte_tokens.push_back(tok);
    endfunction

    // Handle a byte from the start stage; it is always consumed here
    function automatic void start_byte(logic [7:0] c);
        t_kind one;
        one = K_ERROR;
        if (is_alpha(c)) begin
            open_token(ST_ID, c);
        end else if (is_digit(c)) begin
            open_token(ST_NUM, c);
        end else if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
            if (c == CH_NEWLINE) begin
                bump_line();
            end
        end else begin
            case (c)
                "+": one = K_PLUS;
                "-": one = K_MINUS;
                "*": one = K_MUL;
                ";": one = K_SEMI;
                ",": one = K_COMMA;
                "(": one = K_LPAREN;
                ")": one = K_RPAREN;
                "[": one = K_LBRACK;
                "]": one = K_RBRACK;
                "{": one = K_LBRACE;
                "}": one = K_RBRACE;
                "/": begin
                    lex_stage = ST_DIV;
                    tok_start = byte_pos;
                end
                "<": open_token(ST_LESS, c);
                ">": open_token(ST_GREATER, c);
                "=": open_token(ST_ASSIGN, c);
                "!": open_token(ST_NOT, c);
                CH_NUL: begin
                    emit(K_END, byte_pos, '0);
                    halted = 1'b1;
                end
                default: begin
                    emit(K_ERROR, byte_pos, '0);
                    halted = 1'b1;
                end
            endcase
            if (one != K_ERROR) begin
                emit(one, byte_pos, 16'd1);
            end
        end
    endfunction

    // Work out the tokens one source byte causes and queue them
    function automatic void lex_byte(logic [7:0] c);
        bit          taken;
        t_kind       kind;
        t_kind       short_kind;
        t_kind       long_kind;
        logic [47:0] spelled;
        t_token      tok;
        int          i;
        if (halted) begin
            return;
        end
        byte_tokens.delete();
        taken = 1'b1;
        case (lex_stage)
            ST_ID: begin
                if (is_alpha(c)) begin
                    add_char(c);
                end else begin
                    // Match keywords only on the stored spelling of a short word
                    kind = K_ID;
                    if (char_cnt <= KEYWORD_CHARS_DEF) begin
                        spelled = '0;
                        for (i = 0; i < int'(char_cnt); i++) begin
                            spelled = {spelled[39:0], kw_buf[i]};
                        end
                        case (char_cnt)
                            16'd2: if (spelled[15:0] == KW_IF) kind = K_IF;
                            16'd3: if (spelled[23:0] == KW_INT) kind = K_INT;
                            16'd4: begin
                                if (spelled[31:0] == KW_VOID) kind = K_VOID;
                                if (spelled[31:0] == KW_ELSE) kind = K_ELSE;
                            end
                            16'd5: if (spelled[39:0] == KW_WHILE) kind = K_WHILE;
                            16'd6: if (spelled == KW_RETURN) kind = K_RETURN;
                            default: ;
                        endcase
                    end
                    emit(kind, tok_start, char_cnt);
                    taken = 1'b0;
                end
            end
            ST_NUM: begin
                if (is_digit(c)) begin
                    add_char(c);
                end else begin
                    emit(K_NUM, tok_start, char_cnt);
                    taken = 1'b0;
                end
            end
            ST_DIV: begin
                if (c == "*") begin
                    lex_stage = ST_COMMENT;
                end else begin
                    emit(K_DIV, tok_start, 16'd1);
                    taken = 1'b0;
                end
            end
            ST_COMMENT, ST_COMMENT_STAR: begin
                if (c == CH_NUL) begin
                    emit(K_END, byte_pos, '0);
                    halted = 1'b1;
                end else if (lex_stage == ST_COMMENT_STAR && c == "/") begin
                    lex_stage = ST_START;
                end else if (c == "*") begin
                    lex_stage = ST_COMMENT_STAR;
                end else begin
                    lex_stage = ST_COMMENT;
                    if (c == CH_NEWLINE) begin
                        bump_line();
                    end
                end
            end
            ST_LESS, ST_GREATER, ST_ASSIGN: begin
                short_kind = (lex_stage == ST_LESS) ? K_LT :
                             (lex_stage == ST_GREATER) ? K_GT : K_ASSIGN;
                long_kind  = (lex_stage == ST_LESS) ? K_LE :
                             (lex_stage == ST_GREATER) ? K_GE : K_EQ;
                lex_stage = ST_START;
                if (c == "=") begin
                    emit(long_kind, tok_start, 16'd2);
                end else begin
                    emit(short_kind, tok_start, 16'd1);
                    taken = 1'b0;
                end
            end
            ST_NOT: begin
                lex_stage = ST_START;
                if (c == "=") begin
                    emit(K_NE, tok_start, 16'd2);
                end else begin
                    emit(K_ERROR, byte_pos, '0);
                    halted = 1'b1;
                end
            end
            default: start_byte(c);
        endcase

        // A byte that closed a token is looked at again from the start stage
        if (!taken) begin
            lex_stage = ST_START;
            start_byte(c);
        end
        byte_pos = byte_pos + 1'b1;

        // Mark the last token of this byte and hand all of them on
        if (byte_tokens.size() != 0) begin
            tok = byte_tokens.pop_back();
            tok.last = 1'b1;
            byte_tokens.push_back(tok);
        end
        foreach (byte_tokens[j]) begin
            expected_tokens.push_back(byte_tokens[j]);
        end
    endfunction

    // Predict on accepted bytes, compare on accepted tokens
    always @(posedge i_clk) begin : watch
        t_token got;
        t_token want;
        if (!i_rst_n) begin
            lex_stage = ST_START;
            line_cnt  = 16'd1;
            byte_pos  = '0;
            tok_start = '0;
            char_cnt  = '0;
            halted    = 1'b0;
            expected_tokens.delete();
        end else begin
            if (i_push && !i_full) begin
                lex_byte(i_source_byte);
            end
            if (i_pop && !i_empty) begin
                got.kind  = i_token_kind;
                got.line  = i_line_number;
                got.start = i_start_offset;
                got.len   = i_token_length;
                got.last  = i_run_last;
                if (expected_tokens.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("unexpected token: kind %0d line %0d start %0d len %0d last %0b",
                                 got.kind, got.line, got.start, got.len, got.last);
                    end
                end else begin
                    want = expected_tokens.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display("token mismatch: want kind %0d line %0d start %0d len %0d last %0b",
                                     want.kind, want.line, want.start, want.len, want.last);
                            $display("                got  kind %0d line %0d start %0d len %0d last %0b",
                                     got.kind, got.line, got.start, got.len, got.last);
                        end
                    end
                end
            end
        end
        o_mismatch_count <= mismatch_count;
        o_tokens_pending <= expected_tokens.size();
    end

endmodule

### test/c_minus_tokenizer_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_minus_tokenizer_core_test
// Feeds the tokenizer one source text: a short hand-written opening, a random
// stretch of well-formed tokens, comments and blanks, then a random way to
// stop the lexer and a few bytes it must ignore. Both queue sides idle at
// random.
// ----------------------------------------------------------------------------
module c_minus_tokenizer_core_test;
    import ctok_pkg::*;

    localparam int          BODY_BYTES   = 370;
    localparam int          DRAIN_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT  = 20000;
    localparam int unsigned QUIET_FROM   = 150;
    localparam int unsigned QUIET_TO     = 350;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic              push        = 1'b0;
    logic              full;
    logic [7:0]        source_byte = '0;
    logic              empty;
    logic              pop         = 1'b0;
    logic [KIND_W-1:0] token_kind;
    logic [LINE_W-1:0] line_number;
    logic [OFS_W-1:0]  start_offset;
    logic [LEN_W-1:0]  token_length;
    logic              run_last;

    int          mismatch_count;
    int          tokens_pending;
    int unsigned cycle_cnt = 0;
    int unsigned feed_idx  = 0;
    logic [7:0]  src_text [$];

    c_minus_tokenizer_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_source_byte  (source_byte),
        .empty          (empty),
        .pop            (pop),
        .o_token_kind   (token_kind),
        .o_line_number  (line_number),
        .o_start_offset (start_offset),
        .o_token_length (token_length),
        .o_run_last     (run_last)
    );

    c_minus_tokenizer_core_checker u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_full           (full),
        .i_source_byte    (source_byte),
        .i_empty          (empty),
        .i_pop            (pop),
        .i_token_kind     (token_kind),
        .i_line_number    (line_number),
        .i_start_offset   (start_offset),
        .i_token_length   (token_length),
        .i_run_last       (run_last),
        .o_mismatch_count (mismatch_count),
        .o_tokens_pending (tokens_pending)
    );

    always #5 i_clk = ~i_clk;

    // Random idle cycle, except inside one quiet window
    function automatic bit idle_now();
        if (cycle_cnt >= QUIET_FROM && cycle_cnt < QUIET_TO) begin
            return 1'b0;
        end
        return $urandom_range(99) < 23;
    endfunction

    function automatic void put_text(string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            src_text.push_back(s[i]);
        end
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(8))
            0: return 8'h09;
            1: return 8'h0B;
            2: return 8'h0C;
            3: return 8'h0D;
            4, 5, 6: return CH_NEWLINE;
            default: return 8'h20;
        endcase
    endfunction

    function automatic string keyword_text(int idx);
        case (idx)
            0: return "void";
            1: return "int";
            2: return "if";
            3: return "else";
            4: return "while";
            default: return "return";
        endcase
    endfunction

    function automatic string operator_text(int idx);
        case (idx)
            0: return "+";
            1: return "-";
            2: return "*";
            3: return "/";
            4: return "<";
            5: return "<=";
            6: return ">";
            7: return ">=";
            8: return "=";
            9: return "==";
            10: return "!=";
            11: return ";";
            12: return ",";
            13: return "(";
            14: return ")";
            15: return "[";
            16: return "]";
            17: return "{";
            default: return "}";
        endcase
    endfunction

    // Cycle count and watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Present source bytes in order, advancing on each accepted request
    always @(posedge i_clk) begin : feed
        int unsigned next_idx;
        if (!i_rst_n) begin
            push     <= 1'b0;
            feed_idx <= 0;
        end else begin
            next_idx = feed_idx;
            if (push && !full) begin
                next_idx = feed_idx + 1;
            end
            feed_idx <= next_idx;
            if (next_idx < src_text.size() && !idle_now()) begin
                push        <= 1'b1;
                source_byte <= src_text[next_idx];
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Drain tokens with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= !idle_now();
        end
    end

    initial begin : main
        int         pick;
        int         len;
        int         i;
        int         kw_next;
        int         op_next;
        bit         slow_gap;
        logic [7:0] b;
        logic [7:0] prev;

        // Opening: digit right after a letter, byte closing one token and
        // making another, star-star comment close, every blank, two-char
        // operators, token ended by a newline, over-long keyword
        put_text("Zz09 a;9)/*a**/");
        src_text.push_back(8'h20);
        src_text.push_back(8'h09);
        src_text.push_back(8'h0B);
        src_text.push_back(8'h0C);
        src_text.push_back(8'h0D);
        src_text.push_back(CH_NEWLINE);
        put_text("x/y<>=!=return");
        src_text.push_back(CH_NEWLINE);
        put_text("returns(=+ ");

        // Random body of well-formed tokens
        kw_next = $urandom_range(5);
        op_next = $urandom_range(18);
        while (src_text.size() < BODY_BYTES) begin
            pick     = $urandom_range(99);
            slow_gap = 1'b0;
            if (pick < 12) begin
                put_text(keyword_text(kw_next));
                kw_next = (kw_next + 1) % 6;
            end else if (pick < 32) begin
                // Plain words, sometimes close to a keyword
                if ($urandom_range(3) == 0) begin
                    put_text(keyword_text($urandom_range(5)));
                end
                len = $urandom_range(1, 9);
                for (i = 0; i < len; i++) begin
                    if ($urandom_range(1)) begin
                        src_text.push_back(8'("a" + $urandom_range(25)));
                    end else begin
                        src_text.push_back(8'("A" + $urandom_range(25)));
                    end
                end
            end else if (pick < 44) begin
                len = $urandom_range(1, 6);
                for (i = 0; i < len; i++) begin
                    src_text.push_back(8'("0" + $urandom_range(9)));
                end
            end else if (pick < 72) begin
                put_text(operator_text(op_next));
                // Keep slash and star apart from anything that opens a comment
                slow_gap = (op_next == 2 || op_next == 3);
                op_next  = (op_next + 1) % 19;
            end else if (pick < 80) begin
                src_text.push_back(8'h20);
                put_text("/*");
                prev = 8'h00;
                len  = $urandom_range(12);
                for (i = 0; i < len; i++) begin
                    if ($urandom_range(3) == 0) begin
                        b = "*";
                    end else begin
                        b = 8'($urandom_range(1, 255));
                    end
                    if (prev == "*" && b == "/") begin
                        b = "a";
                    end
                    src_text.push_back(b);
                    prev = b;
                end
                put_text("*/");
            end else begin
                len = $urandom_range(1, 4);
                for (i = 0; i < len; i++) begin
                    src_text.push_back(blank_char());
                end
            end
            if (slow_gap || $urandom_range(99) < 55) begin
                src_text.push_back(blank_char());
            end
        end

        // Stop the lexer one of several ways
        case ($urandom_range(3))
            0: begin
                put_text(" abc");
                src_text.push_back(CH_NUL);
            end
            1: begin
                put_text(" /* x");
                src_text.push_back(CH_NUL);
            end
            2: begin
                put_text(" q");
                if ($urandom_range(1)) begin
                    src_text.push_back(8'($urandom_range(128, 255)));
                end else begin
                    case ($urandom_range(5))
                        0: src_text.push_back("@");
                        1: src_text.push_back("#");
                        2: src_text.push_back("_");
                        3: src_text.push_back(".");
                        4: src_text.push_back(8'h7F);
                        default: src_text.push_back(8'h01);
                    endcase
                end
            end
            default: begin
                put_text(" !");
                b = 8'($urandom_range(255));
                if (b == "=") begin
                    b = "x";
                end
                src_text.push_back(b);
            end
        endcase

        // Bytes after the stop must be dropped
        repeat (12) begin
            src_text.push_back(8'($urandom_range(255)));
        end

        // Hold reset, then let the stimulus run out
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (feed_idx < src_text.size()) begin
            @(posedge i_clk);
        end
        while (tokens_pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/ctok_pkg.sv
rtl/ctok_fifo.sv
rtl/ctok_front.sv
rtl/ctok_lexer.sv
rtl/c_minus_tokenizer_core.sv
rtl/ctok_checker.sv
test/c_minus_tokenizer_core_checker.sv
test/c_minus_tokenizer_core_test.sv
